@@ rtl/rgb_spec_text_parser_defines.svh @@
// Assertion macros for the color spec parser.
`ifndef RGB_SPEC_TEXT_PARSER_DEFINES_SVH
`define RGB_SPEC_TEXT_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define RGBSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rgbsp: implication check failed");
`define RGBSP_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("rgbsp: forbidden condition seen");
`else
`define RGBSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RGBSP_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ rtl/rgbsp_pkg.sv @@
package rgbsp_pkg;

    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    localparam logic [11:0] COLOUR_MAX = 12'd255;
    localparam logic [4:0]  HEX_NONE   = 5'd16;

    typedef enum logic [3:0] {
        PH_LEAD      = 4'd0,
        PH_SIGN      = 4'd1,
        PH_ZERO      = 4'd2,
        PH_ZEROX     = 4'd3,
        PH_DIGITS    = 4'd4,
        PH_SEP       = 4'd5,
        PH_HASH_C1   = 4'd6,
        PH_HASH_DIG  = 4'd7,
        PH_HASH_WAIT = 4'd8,
        PH_HASH_DEAD = 4'd9,
        PH_IDLE      = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } t_radix;

    typedef enum logic [1:0] {
        V_UNDECIDED = 2'd0,
        V_OK        = 2'd1,
        V_FAIL      = 2'd2
    } t_verdict;

    typedef struct packed {
        logic       ok;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_result;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // digit value, or HEX_NONE when c is no hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            t = c - CH_ZERO;
            return t[4:0];
        end
        if ((c >= CH_LO_A) && (c <= CH_LO_F)) begin
            t = c - CH_LO_A + 8'd10;
            return t[4:0];
        end
        if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
            t = c - CH_UP_A + 8'd10;
            return t[4:0];
        end
        return HEX_NONE;
    endfunction

endpackage

@@ rtl/rgbsp_in_if.sv @@
interface rgbsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

@@ rtl/rgbsp_out_if.sv @@
interface rgbsp_out_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output ok, output red, output green, output blue,
                    input ready);
    modport sink (input valid, input ok, input red, input green, input blue,
                  output ready);
endinterface

@@ rtl/rgbsp_core.sv @@
module rgbsp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_ch,
    output rgbsp_pkg::t_result  o_result
);

    rgbsp_pkg::t_phase   r_phase,   n_phase;
    rgbsp_pkg::t_radix   r_radix,   n_radix;
    rgbsp_pkg::t_verdict r_verdict, n_verdict;
    rgbsp_pkg::t_verdict w_final;
    logic [1:0]  r_comp,  n_comp;
    logic [1:0]  r_grp,   n_grp;
    logic [7:0]  r_acc,   n_acc;
    logic        r_neg,   n_neg;
    logic [7:0]  r_red,   n_red;
    logic [7:0]  r_green, n_green;
    logic [7:0]  r_blue,  n_blue;

    logic [4:0]  w_h;
    logic        w_hv;
    logic [7:0]  w_dig;
    logic        w_dig_ok;
    logic [11:0] w_prod;
    logic        w_begin, w_end, w_sep, w_close;
    logic [7:0]  w_close_val;
    logic [7:0]  w_tmp;

    assign w_h  = rgbsp_pkg::hex_val(i_ch);
    assign w_hv = !w_h[4];

    always_comb begin
        n_phase     = r_phase;
        n_radix     = r_radix;
        n_verdict   = r_verdict;
        n_comp      = r_comp;
        n_grp       = r_grp;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_red       = r_red;
        n_green     = r_green;
        n_blue      = r_blue;
        w_begin     = 1'b0;
        w_end       = 1'b0;
        w_sep       = 1'b0;
        w_close     = 1'b0;
        w_close_val = 8'd0;
        w_dig       = 8'd0;
        w_dig_ok    = 1'b0;
        w_prod      = 12'd0;
        w_tmp       = i_ch - rgbsp_pkg::CH_ZERO;

        case (r_phase)
            rgbsp_pkg::PH_LEAD: begin
                if (rgbsp_pkg::is_ws(i_ch)) begin
                    n_phase = r_phase;
                end else if (i_ch == rgbsp_pkg::CH_HASH) begin
                    n_grp   = 2'd0;
                    n_phase = rgbsp_pkg::PH_HASH_C1;
                end else if ((i_ch == rgbsp_pkg::CH_PLUS) || (i_ch == rgbsp_pkg::CH_MINUS)) begin
                    n_neg   = (i_ch == rgbsp_pkg::CH_MINUS);
                    n_phase = rgbsp_pkg::PH_SIGN;
                end else begin
                    w_begin = 1'b1;
                end
            end
            rgbsp_pkg::PH_SIGN: begin
                w_begin = 1'b1;
            end
            rgbsp_pkg::PH_ZERO: begin
                if ((i_ch == rgbsp_pkg::CH_LO_X) || (i_ch == rgbsp_pkg::CH_UP_X)) begin
                    n_phase = rgbsp_pkg::PH_ZEROX;
                end else if ((i_ch >= rgbsp_pkg::CH_ZERO) && (i_ch <= rgbsp_pkg::CH_SEVEN)) begin
                    n_radix = rgbsp_pkg::RADIX_OCT;
                    n_acc   = w_tmp;
                    n_phase = rgbsp_pkg::PH_DIGITS;
                end else begin
                    w_end = 1'b1;
                end
            end
            rgbsp_pkg::PH_ZEROX: begin
                if (w_hv) begin
                    n_radix = rgbsp_pkg::RADIX_HEX;
                    n_acc   = {4'd0, w_h[3:0]};
                    n_phase = rgbsp_pkg::PH_DIGITS;
                end else begin
                    w_end = 1'b1;
                end
            end
            rgbsp_pkg::PH_DIGITS: begin
                case (r_radix)
                    rgbsp_pkg::RADIX_HEX: begin
                        w_dig_ok = w_hv;
                        w_dig    = {4'd0, w_h[3:0]};
                        w_prod   = {r_acc, 4'd0} + {4'd0, w_dig};
                    end
                    rgbsp_pkg::RADIX_OCT: begin
                        w_dig_ok = (i_ch >= rgbsp_pkg::CH_ZERO) && (i_ch <= rgbsp_pkg::CH_SEVEN);
                        w_dig    = w_tmp;
                        w_prod   = {1'b0, r_acc, 3'd0} + {4'd0, w_dig};
                    end
                    default: begin
                        w_dig_ok = (i_ch >= rgbsp_pkg::CH_ZERO) && (i_ch <= rgbsp_pkg::CH_NINE);
                        w_dig    = w_tmp;
                        w_prod   = {1'b0, r_acc, 3'd0} + {3'd0, r_acc, 1'b0}
                                 + {4'd0, w_dig};
                    end
                endcase
                if (w_dig_ok) begin
                    if (w_prod > rgbsp_pkg::COLOUR_MAX) begin
                        n_verdict = rgbsp_pkg::V_FAIL;
                        n_phase   = rgbsp_pkg::PH_IDLE;
                    end else begin
                        n_acc = w_prod[7:0];
                    end
                end else begin
                    w_end = 1'b1;
                end
            end
            rgbsp_pkg::PH_SEP: begin
                w_sep = 1'b1;
            end
            rgbsp_pkg::PH_HASH_C1: begin
                n_acc = 8'd0;
                if (rgbsp_pkg::is_ws(i_ch) || (i_ch == rgbsp_pkg::CH_PLUS)) begin
                    n_phase = rgbsp_pkg::PH_HASH_WAIT;
                end else if (i_ch == rgbsp_pkg::CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = rgbsp_pkg::PH_HASH_WAIT;
                end else if (w_hv) begin
                    n_acc   = {4'd0, w_h[3:0]};
                    n_phase = rgbsp_pkg::PH_HASH_DIG;
                end else begin
                    n_phase = rgbsp_pkg::PH_HASH_DEAD;
                end
            end
            rgbsp_pkg::PH_HASH_DIG: begin
                w_close     = 1'b1;
                w_close_val = w_hv ? {r_acc[3:0], w_h[3:0]} : r_acc;
            end
            rgbsp_pkg::PH_HASH_WAIT: begin
                w_close     = 1'b1;
                w_close_val = w_hv ? {4'd0, w_h[3:0]} : 8'd0;
            end
            rgbsp_pkg::PH_HASH_DEAD: begin
                w_close     = 1'b1;
                w_close_val = 8'd0;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (w_end) begin
            if (r_neg && (r_acc != 8'd0)) begin
                n_verdict = rgbsp_pkg::V_FAIL;
                n_phase   = rgbsp_pkg::PH_IDLE;
            end else begin
                case (r_comp)
                    2'd0:    n_red   = r_acc;
                    2'd1:    n_green = r_acc;
                    2'd2:    n_blue  = r_acc;
                    default: n_blue  = r_blue;
                endcase
                if (r_comp >= 2'd2) begin
                    n_verdict = rgbsp_pkg::V_OK;
                    n_phase   = rgbsp_pkg::PH_IDLE;
                end else begin
                    n_comp = r_comp + 2'd1;
                    n_neg  = 1'b0;
                    n_acc  = 8'd0;
                    w_sep  = 1'b1;
                end
            end
        end

        if (w_sep) begin
            if (i_ch == rgbsp_pkg::CH_END) begin
                n_verdict = rgbsp_pkg::V_FAIL;
                n_phase   = rgbsp_pkg::PH_IDLE;
            end else if (w_hv) begin
                w_begin = 1'b1;
            end else begin
                n_phase = rgbsp_pkg::PH_SEP;
            end
        end

        if (w_begin) begin
            if (i_ch == rgbsp_pkg::CH_ZERO) begin
                n_acc   = 8'd0;
                n_phase = rgbsp_pkg::PH_ZERO;
            end else if ((i_ch >= rgbsp_pkg::CH_ONE) && (i_ch <= rgbsp_pkg::CH_NINE)) begin
                n_radix = rgbsp_pkg::RADIX_DEC;
                n_acc   = w_tmp;
                n_phase = rgbsp_pkg::PH_DIGITS;
            end else begin
                n_verdict = rgbsp_pkg::V_FAIL;
                n_phase   = rgbsp_pkg::PH_IDLE;
            end
        end

        if (w_close) begin
            if (r_neg && (w_close_val != 8'd0)) begin
                n_verdict = rgbsp_pkg::V_FAIL;
                n_phase   = rgbsp_pkg::PH_IDLE;
            end else begin
                case (r_grp)
                    2'd0:    n_red   = w_close_val;
                    2'd1:    n_green = w_close_val;
                    2'd2:    n_blue  = w_close_val;
                    default: n_blue  = r_blue;
                endcase
                n_grp = r_grp + 2'd1;
                n_neg = 1'b0;
                n_acc = 8'd0;
                if (r_grp >= 2'd2) begin
                    n_verdict = rgbsp_pkg::V_OK;
                    n_phase   = rgbsp_pkg::PH_IDLE;
                end else begin
                    n_phase = rgbsp_pkg::PH_HASH_C1;
                end
            end
        end
    end

    always_comb begin
        w_final = n_verdict;
        if (n_verdict == rgbsp_pkg::V_UNDECIDED) begin
            w_final = ((n_phase >= rgbsp_pkg::PH_HASH_C1) && (n_phase <= rgbsp_pkg::PH_HASH_DEAD))
                    ? rgbsp_pkg::V_OK : rgbsp_pkg::V_FAIL;
        end
        o_result.ok    = (w_final == rgbsp_pkg::V_OK);
        o_result.red   = o_result.ok ? n_red   : 8'd0;
        o_result.green = o_result.ok ? n_green : 8'd0;
        o_result.blue  = o_result.ok ? n_blue  : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && (i_ch == rgbsp_pkg::CH_END))) begin
            r_phase   <= rgbsp_pkg::PH_LEAD;
            r_radix   <= rgbsp_pkg::RADIX_DEC;
            r_verdict <= rgbsp_pkg::V_UNDECIDED;
            r_comp    <= 2'd0;
            r_grp     <= 2'd0;
            r_acc     <= 8'd0;
            r_neg     <= 1'b0;
            r_red     <= 8'd0;
            r_green   <= 8'd0;
            r_blue    <= 8'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_radix   <= n_radix;
            r_verdict <= n_verdict;
            r_comp    <= n_comp;
            r_grp     <= n_grp;
            r_acc     <= n_acc;
            r_neg     <= n_neg;
            r_red     <= n_red;
            r_green   <= n_green;
            r_blue    <= n_blue;
        end
    end

endmodule

@@ rtl/rgb_spec_text_parser.sv @@
// Color spec parser: takes one character word per cycle on i_in and, for each
// zero word that ends a specification, gives one result word (ok, red, green,
// blue) on o_out. Each character is held in an input register, goes through a
// state update, and a result is loaded into an output register. When a zero
// word advances out of the input register, its result is loaded into the
// output register and o_out.valid rises. Throughput is one word per cycle;
// input stalls only when a zero word meets an output register still holding a
// result that has not been taken.
`include "rgb_spec_text_parser_defines.svh"

module rgb_spec_text_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rgbsp_in_if.sink       i_in,
    rgbsp_out_if.source    o_out
);

    logic               r_in_valid;
    logic [7:0]         r_ch;
    logic               r_out_valid;
    rgbsp_pkg::t_result r_out;
    rgbsp_pkg::t_result w_result;
    logic               w_is_end;
    logic               w_advance;
    logic               w_in_take;
    logic               w_load;

    assign w_is_end  = (r_ch == rgbsp_pkg::CH_END);
    assign w_advance = r_in_valid && (!w_is_end || !r_out_valid || o_out.ready);
    assign w_in_take = i_in.valid && i_in.ready;
    assign w_load    = w_advance && w_is_end;

    assign i_in.ready  = !r_in_valid || w_advance;
    assign o_out.valid = r_out_valid;
    assign o_out.ok    = r_out.ok;
    assign o_out.red   = r_out.red;
    assign o_out.green = r_out.green;
    assign o_out.blue  = r_out.blue;

    rgbsp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_ch     (r_ch),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_in_take) begin
            r_ch <= i_in.ch;
        end
        if (w_load) begin
            r_out <= w_result;
        end
    end

    `RGBSP_ASSERT_IMP(a_result_from_end, i_clk, i_rst_n, $rose(r_out_valid), $past(w_load))
    `RGBSP_ASSERT_IMP(a_fail_zero_colors, i_clk, i_rst_n, r_out_valid && !r_out.ok, r_out[23:0] == 24'd0)
    `RGBSP_ASSERT_NEVER(a_no_result_overwrite, i_clk, i_rst_n, r_out_valid && !o_out.ready && w_load)
    `RGBSP_ASSERT_NEVER(a_no_input_overwrite, i_clk, i_rst_n, r_in_valid && !w_advance && w_in_take)

endmodule

@@ tb/tb_rgb_spec_text_parser.sv @@
`timescale 1ns / 100ps

module tb_rgb_spec_text_parser;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TEXT_DEPTH  = 64;
    localparam int PEND_DEPTH  = 1024;
    localparam int HOLD_OFF    = 80;

    logic i_clk;
    logic i_rst_n;

    rgbsp_in_if  char_if ();
    rgbsp_out_if colour_if ();

    rgb_spec_text_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_if),
        .o_out   (colour_if)
    );

    // parser state mirrored by the predictor
    rgbsp_pkg::t_phase   spec_phase;
    logic [1:0]          spec_comp;
    logic [8:0]          spec_acc;
    logic                spec_neg;
    rgbsp_pkg::t_radix   spec_radix;
    logic [1:0]          spec_groups;
    logic [7:0]          spec_colour [3];
    rgbsp_pkg::t_verdict spec_verdict;

    rgbsp_pkg::t_result pend_colour [PEND_DEPTH];
    int                 pend_wr;
    int                 pend_rd = 0;
    rgbsp_pkg::t_result colour_want;
    logic [7:0]         spec_text [TEXT_DEPTH];
    int                 spec_len;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_reqs = 0;
    int hold_off_seen = 0;
    int hold_off_cycles = 0;
    int items_sent;
    int fail_count = 0;
    int cycle_count = 0;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic char_is_space(input logic [7:0] c);
        return c inside {[rgbsp_pkg::CH_TAB:rgbsp_pkg::CH_CR], rgbsp_pkg::CH_SPACE};
    endfunction

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c inside {[rgbsp_pkg::CH_ZERO:rgbsp_pkg::CH_NINE]}) return {1'b0, c[3:0]};
        if (folded inside {[rgbsp_pkg::CH_LO_A:rgbsp_pkg::CH_LO_F]}) begin
            return {1'b0, folded[3:0]} + 5'd9;
        end
        return rgbsp_pkg::HEX_NONE;
    endfunction

    task automatic clear_spec();
        spec_phase   = rgbsp_pkg::PH_LEAD;
        spec_comp    = 2'd0;
        spec_acc     = 9'd0;
        spec_neg     = 1'b0;
        spec_radix   = rgbsp_pkg::RADIX_DEC;
        spec_groups  = 2'd0;
        spec_colour  = '{8'd0, 8'd0, 8'd0};
        spec_verdict = rgbsp_pkg::V_UNDECIDED;
    endtask

    task automatic abort_spec();
        spec_verdict = rgbsp_pkg::V_FAIL;
        spec_phase   = rgbsp_pkg::PH_IDLE;
    endtask

    task automatic start_number(input logic [7:0] c);
        if (c == rgbsp_pkg::CH_ZERO) begin
            spec_acc   = 9'd0;
            spec_phase = rgbsp_pkg::PH_ZERO;
        end else if (c inside {[rgbsp_pkg::CH_ONE:rgbsp_pkg::CH_NINE]}) begin
            spec_radix = rgbsp_pkg::RADIX_DEC;
            spec_acc   = {5'd0, c[3:0]};
            spec_phase = rgbsp_pkg::PH_DIGITS;
        end else begin
            abort_spec();
        end
    endtask

    task automatic after_separator(input logic [7:0] c);
        if (c == rgbsp_pkg::CH_END) begin
            abort_spec();
        end else if (digit_of(c) != rgbsp_pkg::HEX_NONE) begin
            start_number(c);
        end else begin
            spec_phase = rgbsp_pkg::PH_SEP;
        end
    endtask

    task automatic finish_number(input logic [7:0] c);
        if (spec_neg && spec_acc != 9'd0) begin
            abort_spec();
        end else begin
            spec_colour[spec_comp] = spec_acc[7:0];
            if (spec_comp >= 2'd2) begin
                spec_verdict = rgbsp_pkg::V_OK;
                spec_phase   = rgbsp_pkg::PH_IDLE;
            end else begin
                spec_comp = spec_comp + 2'd1;
                spec_neg  = 1'b0;
                spec_acc  = 9'd0;
                after_separator(c);
            end
        end
    endtask

    task automatic finish_group();
        if (spec_neg && spec_acc != 9'd0) begin
            abort_spec();
        end else begin
            spec_colour[spec_groups] = spec_acc[7:0];
            spec_groups = spec_groups + 2'd1;
            spec_neg    = 1'b0;
            spec_acc    = 9'd0;
            if (spec_groups == 2'd3) begin
                spec_verdict = rgbsp_pkg::V_OK;
                spec_phase   = rgbsp_pkg::PH_IDLE;
            end else begin
                spec_phase = rgbsp_pkg::PH_HASH_C1;
            end
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic [4:0] h;
        int d;
        int base;
        int v;
        h = digit_of(c);
        case (spec_phase)
            rgbsp_pkg::PH_LEAD: begin
                if (!char_is_space(c)) begin
                    if (c == rgbsp_pkg::CH_HASH) begin
                        spec_groups = 2'd0;
                        spec_phase  = rgbsp_pkg::PH_HASH_C1;
                    end else if (c == rgbsp_pkg::CH_PLUS || c == rgbsp_pkg::CH_MINUS) begin
                        spec_neg   = (c == rgbsp_pkg::CH_MINUS);
                        spec_phase = rgbsp_pkg::PH_SIGN;
                    end else begin
                        start_number(c);
                    end
                end
            end
            rgbsp_pkg::PH_SIGN: start_number(c);
            rgbsp_pkg::PH_ZERO: begin
                if (c == rgbsp_pkg::CH_LO_X || c == rgbsp_pkg::CH_UP_X) begin
                    spec_phase = rgbsp_pkg::PH_ZEROX;
                end else if (c inside {[rgbsp_pkg::CH_ZERO:rgbsp_pkg::CH_SEVEN]}) begin
                    spec_radix = rgbsp_pkg::RADIX_OCT;
                    spec_acc   = {6'd0, c[2:0]};
                    spec_phase = rgbsp_pkg::PH_DIGITS;
                end else begin
                    finish_number(c);
                end
            end
            rgbsp_pkg::PH_ZEROX: begin
                if (h != rgbsp_pkg::HEX_NONE) begin
                    spec_radix = rgbsp_pkg::RADIX_HEX;
                    spec_acc   = {4'd0, h};
                    spec_phase = rgbsp_pkg::PH_DIGITS;
                end else begin
                    finish_number(c);
                end
            end
            rgbsp_pkg::PH_DIGITS: begin
                case (spec_radix)
                    rgbsp_pkg::RADIX_HEX: begin
                        d    = int'(h);
                        base = 16;
                    end
                    rgbsp_pkg::RADIX_OCT: begin
                        d    = (c inside {[rgbsp_pkg::CH_ZERO:rgbsp_pkg::CH_SEVEN]})
                             ? int'(c[2:0]) : int'(rgbsp_pkg::HEX_NONE);
                        base = 8;
                    end
                    default: begin
                        d    = (c inside {[rgbsp_pkg::CH_ZERO:rgbsp_pkg::CH_NINE]})
                             ? int'(c[3:0]) : int'(rgbsp_pkg::HEX_NONE);
                        base = 10;
                    end
                endcase
                if (d == int'(rgbsp_pkg::HEX_NONE)) begin
                    finish_number(c);
                end else begin
                    v = int'(spec_acc) * base + d;
                    if (v > int'(rgbsp_pkg::COLOUR_MAX)) abort_spec();
                    else spec_acc = v[8:0];
                end
            end
            rgbsp_pkg::PH_SEP: after_separator(c);
            rgbsp_pkg::PH_HASH_C1: begin
                spec_acc = 9'd0;
                if (char_is_space(c) || c == rgbsp_pkg::CH_PLUS) begin
                    spec_phase = rgbsp_pkg::PH_HASH_WAIT;
                end else if (c == rgbsp_pkg::CH_MINUS) begin
                    spec_neg   = 1'b1;
                    spec_phase = rgbsp_pkg::PH_HASH_WAIT;
                end else if (h != rgbsp_pkg::HEX_NONE) begin
                    spec_acc   = {4'd0, h};
                    spec_phase = rgbsp_pkg::PH_HASH_DIG;
                end else begin
                    spec_phase = rgbsp_pkg::PH_HASH_DEAD;
                end
            end
            rgbsp_pkg::PH_HASH_DIG: begin
                if (h != rgbsp_pkg::HEX_NONE) spec_acc = spec_acc * 9'd16 + {4'd0, h};
                finish_group();
            end
            rgbsp_pkg::PH_HASH_WAIT: begin
                spec_acc = (h != rgbsp_pkg::HEX_NONE) ? {4'd0, h} : 9'd0;
                finish_group();
            end
            rgbsp_pkg::PH_HASH_DEAD: begin
                spec_acc = 9'd0;
                finish_group();
            end
            default: begin
            end
        endcase
    endtask

    task automatic predict_colour(input logic [7:0] c);
        rgbsp_pkg::t_result r;
        parse_char(c);
        if (c == rgbsp_pkg::CH_END) begin
            if (spec_verdict == rgbsp_pkg::V_UNDECIDED) begin
                spec_verdict = (spec_phase inside
                               {[rgbsp_pkg::PH_HASH_C1:rgbsp_pkg::PH_HASH_DEAD]})
                             ? rgbsp_pkg::V_OK : rgbsp_pkg::V_FAIL;
            end
            r.ok    = (spec_verdict == rgbsp_pkg::V_OK);
            r.red   = r.ok ? spec_colour[0] : 8'd0;
            r.green = r.ok ? spec_colour[1] : 8'd0;
            r.blue  = r.ok ? spec_colour[2] : 8'd0;
            pend_colour[pend_wr % PEND_DEPTH] = r;
            pend_wr++;
            clear_spec();
        end
    endtask

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            char_if.ch = 8'($urandom_range(0, 255));
            @(negedge i_clk);
        end
        char_if.valid = 1'b1;
        char_if.ch    = c;
        @(posedge i_clk);
        while (!char_if.ready) @(posedge i_clk);
        predict_colour(c);
        items_sent++;
        @(negedge i_clk);
        char_if.valid = 1'b0;
    endtask

    task automatic add_char(input logic [7:0] c);
        if (spec_len < TEXT_DEPTH) begin
            spec_text[spec_len] = c;
            spec_len++;
        end
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    task automatic send_spec_text();
        for (int i = 0; i < spec_len; i++) send_char(spec_text[i]);
        send_char(rgbsp_pkg::CH_END);
        spec_len = 0;
    endtask

    task automatic send_spec(input string s);
        add_str(s);
        send_spec_text();
    endtask

    task automatic wait_drained();
        while (pend_rd != pend_wr) @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_space();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? rgbsp_pkg::CH_SPACE : rgbsp_pkg::CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] pick_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] pick_non_hex();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (digit_of(b) != rgbsp_pkg::HEX_NONE);
        return b;
    endfunction

    task automatic add_junk(input int max_len);
        repeat ($urandom_range(0, max_len)) add_char(8'($urandom_range(1, 255)));
    endtask

    task automatic gen_hash_spec();
        int groups;
        logic [7:0] lead;
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 2)) add_char(pick_space());
        add_char(rgbsp_pkg::CH_HASH);
        groups = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 3;
        for (int g = 0; g < groups; g++) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    add_char(pick_hex());
                    add_char(pick_hex());
                end
                2: begin
                    add_char(pick_hex());
                    add_char(pick_non_hex());
                end
                3: begin
                    case ($urandom_range(0, 2))
                        0: lead = pick_space();
                        1: lead = rgbsp_pkg::CH_PLUS;
                        default: lead = rgbsp_pkg::CH_MINUS;
                    endcase
                    add_char(lead);
                    add_char($urandom_range(0, 1) ? rgbsp_pkg::CH_ZERO : pick_hex());
                end
                4: add_str($urandom_range(0, 1) ? "0x" : "0X");
                default: begin
                    add_char(8'($urandom_range(1, 255)));
                    add_char(8'($urandom_range(1, 255)));
                end
            endcase
        end
        if (groups < 3 && $urandom_range(0, 1)) add_char(pick_hex());
        if ($urandom_range(0, 2) == 0) add_junk(3);
    endtask

    task automatic add_number(input logic negative);
        int v;
        string digits;
        if (negative && $urandom_range(0, 1)) begin
            add_str("0");
            return;
        end
        if ($urandom_range(0, 9) == 0) begin
            add_char(8'($urandom_range(rgbsp_pkg::CH_LO_A, rgbsp_pkg::CH_LO_F)));
        end
        case ($urandom_range(0, 2))
            0: begin
                v = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255);
                add_str($sformatf("%0d", v));
            end
            1: begin
                v = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 511) : $urandom_range(0, 255);
                add_str({"0", $sformatf("%0o", v)});
            end
            default: begin
                v = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 511) : $urandom_range(0, 255);
                digits = $sformatf("%0h", v);
                if ($urandom_range(0, 1)) digits = digits.toupper();
                add_str($urandom_range(0, 1) ? "0x" : "0X");
                if ($urandom_range(0, 9) != 0) add_str(digits);
            end
        endcase
    endtask

    task automatic gen_integer_spec();
        int count;
        logic negative;
        negative = 1'b0;
        count = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 3;
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) add_char(pick_space());
        if ($urandom_range(0, 2) == 0) begin
            negative = 1'($urandom_range(0, 1));
            add_char(negative ? rgbsp_pkg::CH_MINUS : rgbsp_pkg::CH_PLUS);
        end
        for (int i = 0; i < count; i++) begin
            if (i > 0) repeat ($urandom_range(1, 3)) add_char(pick_non_hex());
            add_number(negative && i == 0);
        end
        if (count < 3 && $urandom_range(0, 1)) add_char(pick_non_hex());
        if ($urandom_range(0, 2) == 0) add_junk(3);
    endtask

    task automatic test_hash_forms();
        send_spec("#ff0080");
        send_spec("\t #FFffFF trailing");
        send_spec("#0x+1-0");
        send_spec("# 7g2");
        send_spec("#-1");
        send_spec("#12");
        send_spec("#");
    endtask

    task automatic test_integer_forms();
        send_spec("255 255 255");
        send_spec(" -0 0x0 0");
        send_spec("+1,077;0xFf");
        send_spec("089");
        send_spec("0x/0X 7");
        send_spec("256 1 1");
        send_spec("a1 2 3");
        send_spec("1 2");
        send_spec("1 2 ");
        send_spec("-5 1 2");
        send_spec("1\3772\2003 x");
        send_spec("\377 1 2 3");
        send_spec("");
    endtask

    task automatic test_random_specs(input int count);
        int first;
        first = items_sent;
        while (items_sent - first < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gen_hash_spec();
                4, 5, 6, 7: gen_integer_spec();
                default: add_junk(8);
            endcase
            send_spec_text();
        end
    endtask

    task automatic test_output_backpressure();
        hold_off_reqs++;
        @(negedge i_clk);
        repeat (6) send_spec("1 2 3");
        send_spec("#aabbcc");
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_off_reqs != hold_off_seen) begin
            hold_off_seen   = hold_off_reqs;
            hold_off_cycles = HOLD_OFF;
        end
        if (hold_off_cycles > 0) begin
            colour_if.ready = 1'b0;
            hold_off_cycles--;
        end else begin
            colour_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && colour_if.valid && colour_if.ready) begin
            if (pend_rd == pend_wr) begin
                $display("%0t: result with none expected: expected nothing, actual ok=%0b %0d %0d %0d",
                         $time, colour_if.ok, colour_if.red, colour_if.green, colour_if.blue);
                fail_count++;
            end else begin
                colour_want = pend_colour[pend_rd % PEND_DEPTH];
                pend_rd++;
                check_field("ok", {7'd0, colour_want.ok}, {7'd0, colour_if.ok});
                check_field("red", colour_want.red, colour_if.red);
                check_field("green", colour_want.green, colour_if.green);
                check_field("blue", colour_want.blue, colour_if.blue);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        char_if.valid   = 1'b0;
        char_if.ch      = 8'd0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        items_sent      = 0;
        pend_wr         = 0;
        spec_len        = 0;
        clear_spec();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_hash_forms();
        test_integer_forms();
        wait_drained();

        test_random_specs(50);
        wait_drained();
        send_idle_pct = 62;
        test_random_specs(50);
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 62;
        test_random_specs(50);
        wait_drained();
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        test_random_specs(50);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_output_backpressure();
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pend_rd == pend_wr) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl
rtl/rgbsp_pkg.sv
rtl/rgbsp_in_if.sv
rtl/rgbsp_out_if.sv
rtl/rgbsp_core.sv
rtl/rgb_spec_text_parser.sv
tb/tb_rgb_spec_text_parser.sv
